### hw/rtl/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, constants and character helpers for the HEX record encoder.
// ----------------------------------------------------------------------------
package ihex_pkg;

    localparam int unsigned RECORD_BYTES_DEF = 16;
    localparam int unsigned BYTE_W           = 8;
    localparam int unsigned CNT_W            = 5;
    localparam int unsigned ADDR_W           = 16;
    localparam int unsigned END_LEN          = 11;

    localparam logic [1:0] HDR_COUNT   = 2'd0;
    localparam logic [1:0] HDR_ADDR_HI = 2'd1;
    localparam logic [1:0] HDR_ADDR_LO = 2'd2;
    localparam logic [1:0] HDR_TYPE    = 2'd3;

    localparam logic [BYTE_W-1:0] CHR_COLON     = 8'h3A;
    localparam logic [BYTE_W-1:0] CHR_NL        = 8'h0A;
    localparam logic [BYTE_W-1:0] CHR_ZERO      = 8'h30;
    localparam logic [BYTE_W-1:0] CHR_ONE       = 8'h31;
    localparam logic [BYTE_W-1:0] CHR_F         = 8'h46;
    localparam logic [BYTE_W-1:0] REC_TYPE_DATA = 8'h00;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COLON,
        S_HDR,
        S_DATA,
        S_CSUM,
        S_NL,
        S_END
    } t_state;

    typedef struct packed {
        logic clr;
        logic add;
    } t_chk_ctl;

    function automatic logic [BYTE_W-1:0] f_hex(input logic [3:0] v);
        logic [BYTE_W-1:0] w;
        w = {4'h0, v};
        return (v < 4'd10) ? (CHR_ZERO + w) : (8'h37 + w);
    endfunction

    // end record text ":00000001FF"
    function automatic logic [BYTE_W-1:0] f_end_char(input logic [3:0] i);
        logic [BYTE_W-1:0] c;
        case (i)
            4'd0:    c = CHR_COLON;
            4'd8:    c = CHR_ONE;
            4'd9:    c = CHR_F;
            4'd10:   c = CHR_F;
            default: c = CHR_ZERO;
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/ihex_in_if.sv
// ----------------------------------------------------------------------------
// ihex_in_if
// Input channel: one raw data byte per word with a final flag.
// ----------------------------------------------------------------------------
interface ihex_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

### hw/rtl/ihex_out_if.sv
// ----------------------------------------------------------------------------
// ihex_out_if
// Output channel: one ASCII character per word with a run-last flag.
// ----------------------------------------------------------------------------
interface ihex_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] ascii_char;
    logic       run_last;

    modport source (output valid, output ascii_char, output run_last, input ready);
    modport sink   (input valid, input ascii_char, input run_last, output ready);
endinterface

### hw/rtl/intel_hex_record_encoder_top.sv
// ----------------------------------------------------------------------------
// intel_hex_record_encoder_top
// Buffers raw bytes into HEX data records and streams them out as ASCII.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : one data byte per word, final_byte marks the last byte of an image.
//   o_out : one ASCII character per word; run_last marks the last character
//           caused by one input word.
//   A byte that neither fills a record nor is final is taken and gives no
//   output. A byte that closes a record of N bytes starts a record of
//   2*N+12 characters (plus 11 for the end record when final), sent at one
//   character per cycle while the receiver keeps up, through a single output
//   register; the sequencer walks the record one hex digit a cycle, sharing
//   one hex converter and one checksum adder. i_in.ready stays low until the
//   last character of the record is loaded into the output register, so the
//   input takes no new byte while a record is being sent.
//   A receiver stall freezes the sequencer; nothing is lost.
//   Reset clears the fill count and load address to zero and empties the
//   output register.
// ----------------------------------------------------------------------------
module intel_hex_record_encoder_top
    import ihex_pkg::*;
#(
    parameter int unsigned RECORD_BYTES = RECORD_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ihex_in_if.sink       i_in,
    ihex_out_if.source    o_out
);

    localparam int unsigned IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_nib, n_nib;
    logic [CNT_W-1:0]    r_fill;
    logic [CNT_W-1:0]    r_count;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_final;
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_char;
    logic                r_out_last;

    logic                w_accept;
    logic                w_adv;
    logic                w_emit;
    logic [CNT_W-1:0]    w_fill_inc;
    logic [BYTE_W-1:0]   w_byte;
    logic [BYTE_W-1:0]   w_nib_char;
    logic [BYTE_W-1:0]   w_char;
    logic                w_last;
    logic [BYTE_W-1:0]   w_rdata;
    logic [BYTE_W-1:0]   w_csum;
    t_chk_ctl            w_chk_ctl;

    assign i_in.ready   = (r_state == S_IDLE);
    assign w_accept     = i_in.valid && i_in.ready;
    assign w_adv        = (r_state != S_IDLE) && (!r_out_valid || o_out.ready);
    assign w_fill_inc   = r_fill + CNT_W'(1);
    assign w_emit       = (w_fill_inc >= CNT_W'(RECORD_BYTES)) || i_in.final_byte;

    assign o_out.valid      = r_out_valid;
    assign o_out.ascii_char = r_out_char;
    assign o_out.run_last   = r_out_last;

    ihex_buf #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_fill[IDX_W-1:0]),
        .i_wdata (i_in.data_byte),
        .i_raddr (n_idx[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    ihex_chk u_chk (
        .i_clk  (i_clk),
        .i_ctl  (w_chk_ctl),
        .i_byte (w_byte),
        .o_csum (w_csum)
    );

    always_comb begin
        case (r_state)
            S_HDR: begin
                case (r_idx[1:0])
                    HDR_COUNT:   w_byte = BYTE_W'(r_count);
                    HDR_ADDR_HI: w_byte = r_addr[15:8];
                    HDR_ADDR_LO: w_byte = r_addr[7:0];
                    default:     w_byte = REC_TYPE_DATA;
                endcase
            end
            S_DATA:  w_byte = w_rdata;
            S_CSUM:  w_byte = w_csum;
            default: w_byte = '0;
        endcase
    end

    assign w_nib_char = f_hex(r_nib ? w_byte[3:0] : w_byte[7:4]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_nib   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_nib   <= n_nib;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_nib         = r_nib;
        w_char        = w_nib_char;
        w_last        = 1'b0;
        w_chk_ctl.clr = 1'b0;
        w_chk_ctl.add = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_chk_ctl.clr = 1'b1;
                    if (w_emit) begin
                        n_state = S_COLON;
                    end
                end
            end
            S_COLON: begin
                w_char = CHR_COLON;
                if (w_adv) begin
                    n_state = S_HDR;
                    n_idx   = '0;
                    n_nib   = 1'b0;
                end
            end
            S_HDR: begin
                if (w_adv) begin
                    w_chk_ctl.add = !r_nib;
                    n_nib         = !r_nib;
                    if (r_nib) begin
                        if (r_idx[1:0] == HDR_TYPE) begin
                            n_state = S_DATA;
                            n_idx   = '0;
                        end else begin
                            n_idx = r_idx + CNT_W'(1);
                        end
                    end
                end
            end
            S_DATA: begin
                if (w_adv) begin
                    w_chk_ctl.add = !r_nib;
                    n_nib         = !r_nib;
                    if (r_nib) begin
                        if (r_idx + CNT_W'(1) == r_count) begin
                            n_state = S_CSUM;
                            n_idx   = '0;
                        end else begin
                            n_idx = r_idx + CNT_W'(1);
                        end
                    end
                end
            end
            S_CSUM: begin
                if (w_adv) begin
                    n_nib = !r_nib;
                    if (r_nib) begin
                        n_state = S_NL;
                    end
                end
            end
            S_NL: begin
                w_char = CHR_NL;
                w_last = !r_final;
                if (w_adv) begin
                    n_state = r_final ? S_END : S_IDLE;
                    n_idx   = '0;
                end
            end
            S_END: begin
                w_char = f_end_char(r_idx[3:0]);
                w_last = (r_idx == CNT_W'(END_LEN - 1));
                if (w_adv) begin
                    if (w_last) begin
                        n_state = S_IDLE;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_addr  <= '0;
            r_count <= '0;
            r_final <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fill  <= w_emit ? '0 : w_fill_inc;
                r_count <= w_fill_inc;
                r_final <= i_in.final_byte;
            end
            if (w_adv && (r_state == S_NL)) begin
                r_addr <= r_final ? '0 : (r_addr + ADDR_W'(r_count));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_char <= w_char;
            r_out_last <= w_last;
        end
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < CNT_W'(RECORD_BYTES))
        else $error("fill count out of range");

    a_final_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.final_byte) |=> (r_state == S_COLON))
        else $error("final byte did not start a record");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_last) |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after last character");

endmodule

### hw/rtl/ihex_buf.sv
// ----------------------------------------------------------------------------
// ihex_buf
// Record data buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ihex_buf
    import ihex_pkg::*;
#(
    parameter int unsigned RECORD_BYTES = RECORD_BYTES_DEF
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_we,
    input  logic [((RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1)-1:0] i_waddr,
    input  logic [BYTE_W-1:0]                                    i_wdata,
    input  logic [((RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1)-1:0] i_raddr,
    output logic [BYTE_W-1:0]                                    o_rdata
);

    logic [BYTE_W-1:0] r_mem [RECORD_BYTES];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/ihex_chk.sv
// ----------------------------------------------------------------------------
// ihex_chk
// Shared checksum accumulator; yields the two's-complement checksum.
// ----------------------------------------------------------------------------
module ihex_chk
    import ihex_pkg::*;
(
    input  logic              i_clk,
    input  t_chk_ctl          i_ctl,
    input  logic [BYTE_W-1:0] i_byte,
    output logic [BYTE_W-1:0] o_csum
);

    logic [BYTE_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_sum <= '0;
        end else if (i_ctl.add) begin
            r_sum <= r_sum + i_byte;
        end
    end

    assign o_csum = BYTE_W'(0) - r_sum;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives raw image bytes into the HEX record encoder and checks every
// character that comes out. A built-in encoder predicts each record; a short
// directed table pins the reset, all-ones and checksum-zero records, then
// random images follow.
// ----------------------------------------------------------------------------
module testbench
    import ihex_pkg::*;
();

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_hex_char;

    typedef struct {
        logic [7:0] d;
        logic       f;
        string      text;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ihex_in_if  in_if ();
    ihex_out_if out_if ();

    intel_hex_record_encoder_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #10 i_clk = ~i_clk;

    // encoder state
    logic [7:0]        rec_bytes [RECORD_BYTES_DEF];
    logic [CNT_W-1:0]  fill_cnt  = '0;
    logic [ADDR_W-1:0] load_addr = '0;
    logic [7:0]        line_text [$];
    string             hex_set = "0123456789ABCDEF";

    t_hex_char expected_chars [$];
    string     pinned_text [$];
    int        errors       = 0;
    int        in_accepts   = 0;
    bit        quiet_tail   = 1'b0;
    bit        holdoff_done = 1'b0;
    int        calm_words   = 0;

    t_stim_row dir_rows [21] = '{
        '{8'h00, 1'b1, ":0100000000FF\n:00000001FF"},
        '{8'hFF, 1'b1, ":01000000FF00\n:00000001FF"},
        '{8'hFF, 1'b0, ""}, '{8'hFF, 1'b0, ""}, '{8'hFF, 1'b0, ""}, '{8'hFF, 1'b0, ""},
        '{8'hFF, 1'b0, ""}, '{8'hFF, 1'b0, ""}, '{8'hFF, 1'b0, ""}, '{8'hFF, 1'b0, ""},
        '{8'hFF, 1'b0, ""}, '{8'hFF, 1'b0, ""}, '{8'hFF, 1'b0, ""}, '{8'hFF, 1'b0, ""},
        '{8'hFF, 1'b0, ""}, '{8'hFF, 1'b0, ""}, '{8'hFF, 1'b0, ""},
        '{8'hFF, 1'b0, {":10000000", "FFFFFFFFFFFFFFFF", "FFFFFFFFFFFFFFFF", "00\n"}},
        '{8'h5A, 1'b1, ""},
        '{8'h12, 1'b0, ""},
        '{8'h34, 1'b1, ""}
    };

    function automatic void put_hex(input logic [7:0] v);
        line_text.push_back(hex_set[v[7:4]]);
        line_text.push_back(hex_set[v[3:0]]);
    endfunction

    function automatic void put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_text.push_back(s[i]);
    endfunction

    // one input byte; leaves the characters it causes in line_text
    function automatic void encode_byte(input logic [7:0] d, input logic f);
        logic [7:0] sum;
        int         i;
        line_text.delete();
        rec_bytes[fill_cnt[3:0]] = d;
        fill_cnt = fill_cnt + 1'b1;
        if (fill_cnt < RECORD_BYTES_DEF && !f)
            return;
        sum = {3'b000, fill_cnt} + load_addr[15:8] + load_addr[7:0];
        put_text(":");
        put_hex({3'b000, fill_cnt});
        put_hex(load_addr[15:8]);
        put_hex(load_addr[7:0]);
        put_hex(REC_TYPE_DATA);
        for (i = 0; i < fill_cnt; i++) begin
            put_hex(rec_bytes[i]);
            sum = sum + rec_bytes[i];
        end
        put_hex(8'h00 - sum);
        put_text("\n");
        load_addr = load_addr + fill_cnt;
        fill_cnt  = '0;
        if (f) begin
            put_text(":00000001FF");
            load_addr = '0;
        end
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic [7:0] d, input logic f, input string pin);
        int r;
        pinned_text.push_back(pin);
        if (!quiet_tail && calm_words == 0) begin
            r = $urandom_range(0, 19);
            if (r < 5) begin
                in_if.valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else if (r == 5) begin
                calm_words = $urandom_range(10, 40);
            end
        end else if (calm_words > 0) begin
            calm_words--;
        end
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= d;
        in_if.final_byte <= f;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    always @(posedge i_clk) begin
        string     pin;
        t_hex_char got;
        t_hex_char want;
        int        k;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                in_accepts++;
                encode_byte(in_if.data_byte, in_if.final_byte);
                pin = pinned_text.pop_front();
                if (pin.len() != 0) begin
                    line_text.delete();
                    put_text(pin);
                end
                for (k = 0; k < line_text.size(); k++)
                    expected_chars.push_back('{line_text[k], k == line_text.size() - 1});
            end
            if (out_if.valid && out_if.ready) begin
                got = '{out_if.ascii_char, out_if.run_last};
                if (expected_chars.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none actual %h/%b",
                             $time, got.ch, got.last);
                end else begin
                    want = expected_chars.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: word mismatch, expected %h/%b actual %h/%b",
                                 $time, want.ch, want.last, got.ch, got.last);
                    end
                end
            end
        end
    end

    // receiver
    initial begin
        int r;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            r = $urandom_range(0, 19);
            if (!holdoff_done && in_accepts >= 40) begin
                holdoff_done = 1'b1;
                out_if.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                out_if.ready <= 1'b1;
            end else if (!quiet_tail && r < 4) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                out_if.ready <= 1'b1;
            end else if (!quiet_tail && r == 4) begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int n;
        int len;
        int r;
        int random_sent;
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.data_byte  <= 8'h00;
        in_if.final_byte <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].d, dir_rows[i].f, dir_rows[i].text);

        random_sent = 0;
        while (random_sent < 250) begin
            r = $urandom_range(0, 9);
            if (r < 3)
                len = $urandom_range(1, 3);
            else if (r < 5)
                len = 16 * $urandom_range(1, 2);
            else if (r == 5)
                len = $urandom_range(0, 1) ? 15 : 17;
            else
                len = $urandom_range(1, 40);
            for (n = 1; n <= len; n++) begin
                send_word(pick_byte(), n == len, "");
                random_sent++;
            end
            quiet_tail = (random_sent >= 200);
        end
        in_if.valid <= 1'b0;

        @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
